FILE: rtl/clt_pkg.sv
// Shared types and constants for the command line tokenizer.
package clt_pkg;

	localparam int CHAR_W   = 8;
	localparam int RUN_W    = 8;
	localparam int TOTAL_W  = 13;

	localparam int MAX_BACKSLASH_RUN = 255;
	localparam int MAX_LINE_LENGTH   = 4096;

	localparam int RUN_LIMIT_I   = (MAX_BACKSLASH_RUN > 255) ? 255 : MAX_BACKSLASH_RUN;
	localparam int TOTAL_CAP_I   = 8191;
	localparam int ARG_LIMIT_I   = (MAX_LINE_LENGTH > TOTAL_CAP_I) ? TOTAL_CAP_I : MAX_LINE_LENGTH;

	localparam logic [RUN_W-1:0]   RUN_LIMIT = RUN_W'(RUN_LIMIT_I);
	localparam logic [TOTAL_W-1:0] TOTAL_CAP = TOTAL_W'(TOTAL_CAP_I);
	localparam logic [TOTAL_W-1:0] ARG_LIMIT = TOTAL_W'(ARG_LIMIT_I);

	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic              is_nul;
		logic              is_ws;
		logic              is_quote;
		logic              is_bslash;
		logic [CHAR_W-1:0] ch;
	} char_class_t;

endpackage

FILE: rtl/clt_front.sv
// Input side: classify each accepted character and push it to the queue.
module clt_front import clt_pkg::*; (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] in_char,
	input  logic              q_full,
	output logic              q_push,
	output char_class_t       q_wdata
);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_wdata.ch        = in_char;
		q_wdata.is_nul    = (in_char == CH_NUL);
		q_wdata.is_quote  = (in_char == CH_QUOTE);
		q_wdata.is_bslash = (in_char == CH_BSLASH);
		q_wdata.is_ws     = (in_char inside {CH_SPACE, CH_TAB, CH_CR, CH_LF});
	end

endmodule

FILE: rtl/clt_queue.sv
// Short queue of classified characters between front and back.
module clt_queue import clt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  char_class_t wdata,
	output logic        full,
	input  logic        pop,
	output logic        not_empty,
	output char_class_t rdata
);

	char_class_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop) else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

FILE: rtl/clt_back.sv
// Tokenizer state and result register: executes one queued character per cycle unless the output stalls.
module clt_back import clt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  char_class_t        q_rdata,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [RUN_W-1:0]   lead_backslashes,
	output logic               char_valid,
	output logic [CHAR_W-1:0]  out_char,
	output logic               arg_start,
	output logic               arg_end,
	output logic               line_done,
	output logic [TOTAL_W-1:0] arg_total,
	output logic [TOTAL_W-1:0] char_total
);

	logic               in_arg_q, in_quotes_q, close_pend_q;
	logic [RUN_W-1:0]   run_q;
	logic [TOTAL_W-1:0] arg_cnt_q, char_cnt_q;

	logic               in_arg_d, in_quotes_d, close_pend_d;
	logic [RUN_W-1:0]   run_d;
	logic [TOTAL_W-1:0] arg_cnt_d, char_cnt_d;

	logic [RUN_W-1:0]   lead;
	logic               valid_c, start_c, end_c, done_c, has_result;
	logic [CHAR_W-1:0]  ochar;
	logic [TOTAL_W-1:0] atot, ctot;
	logic [TOTAL_W-1:0] arg_inc;
	logic [TOTAL_W:0]   arg_sum, char_sum;

	logic               out_valid_q, char_valid_q, arg_start_q, arg_end_q, line_done_q;
	logic [RUN_W-1:0]   lead_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic [TOTAL_W-1:0] arg_total_q, char_total_q;

	assign q_pop = q_not_empty && (!out_valid_q || out_ready);

	assign arg_sum = {1'b0, arg_cnt_q} + (TOTAL_W + 1)'(1);
	assign arg_inc = (arg_sum > {1'b0, ARG_LIMIT}) ? ARG_LIMIT : arg_sum[TOTAL_W-1:0];

	always_comb begin
		in_arg_d     = in_arg_q;
		in_quotes_d  = in_quotes_q;
		close_pend_d = 1'b0;
		run_d        = run_q;
		arg_cnt_d    = arg_cnt_q;
		lead         = '0;
		valid_c      = 1'b0;
		start_c      = 1'b0;
		end_c        = 1'b0;
		done_c       = 1'b0;
		ochar        = '0;
		atot         = '0;
		if (q_rdata.is_nul) begin
			if (in_arg_q) begin
				lead  = run_q;
				end_c = 1'b1;
			end
			done_c = 1'b1;
			atot   = arg_inc;
		end else if (in_arg_q || !q_rdata.is_ws) begin
			if (!in_arg_q) begin
				in_arg_d  = 1'b1;
				start_c   = 1'b1;
				arg_cnt_d = arg_inc;
			end
			if (close_pend_q && q_rdata.is_quote) begin
				valid_c = 1'b1;
				ochar   = CH_QUOTE;
			end else if (q_rdata.is_bslash) begin
				if (run_q < RUN_LIMIT) begin
					run_d = run_q + 1'b1;
				end
			end else begin
				run_d = '0;
				if (q_rdata.is_quote) begin
					lead = run_q >> 1;
					if (!run_q[0]) begin
						if (in_quotes_q) begin
							in_quotes_d  = 1'b0;
							close_pend_d = 1'b1;
						end else begin
							in_quotes_d = 1'b1;
						end
					end else begin
						valid_c = 1'b1;
						ochar   = CH_QUOTE;
					end
				end else begin
					lead = run_q;
					if (q_rdata.is_ws && !in_quotes_q) begin
						end_c    = 1'b1;
						in_arg_d = 1'b0;
					end else begin
						valid_c = 1'b1;
						ochar   = q_rdata.ch;
					end
				end
			end
		end
		char_sum = {1'b0, char_cnt_q} + (TOTAL_W + 1)'(lead) + (TOTAL_W + 1)'(valid_c)
			+ (TOTAL_W + 1)'(end_c);
		char_cnt_d = (char_sum > {1'b0, TOTAL_CAP}) ? TOTAL_CAP : char_sum[TOTAL_W-1:0];
		ctot       = done_c ? char_cnt_d : '0;
		has_result = (lead != '0) || valid_c || start_c || end_c || done_c;
		if (q_rdata.is_nul) begin
			in_arg_d     = 1'b0;
			in_quotes_d  = 1'b0;
			close_pend_d = 1'b0;
			run_d        = '0;
			arg_cnt_d    = '0;
			char_cnt_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_arg_q     <= 1'b0;
			in_quotes_q  <= 1'b0;
			close_pend_q <= 1'b0;
			run_q        <= '0;
			arg_cnt_q    <= '0;
			char_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				in_arg_q     <= in_arg_d;
				in_quotes_q  <= in_quotes_d;
				close_pend_q <= close_pend_d;
				run_q        <= run_d;
				arg_cnt_q    <= arg_cnt_d;
				char_cnt_q   <= char_cnt_d;
			end
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop && has_result) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && has_result) begin
			lead_q       <= lead;
			char_valid_q <= valid_c;
			out_char_q   <= ochar;
			arg_start_q  <= start_c;
			arg_end_q    <= end_c;
			line_done_q  <= done_c;
			arg_total_q  <= atot;
			char_total_q <= ctot;
		end
	end

	assign out_valid        = out_valid_q;
	assign lead_backslashes = lead_q;
	assign char_valid       = char_valid_q;
	assign out_char         = out_char_q;
	assign arg_start        = arg_start_q;
	assign arg_end          = arg_end_q;
	assign line_done        = line_done_q;
	assign arg_total        = arg_total_q;
	assign char_total       = char_total_q;

`ifndef SYNTHESIS
	a_quotes_in_arg: assert property (@(posedge clk) disable iff (!arst_n)
		in_quotes_q |-> in_arg_q) else $error("quoting outside an argument");
	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_rdata.is_nul |=> !in_arg_q && !in_quotes_q && run_q == '0
			&& arg_cnt_q == '0 && char_cnt_q == '0) else $error("state not cleared at line end");
	a_done_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && line_done_q |-> arg_total_q != '0) else $error("zero argument total");
	a_pend_after_quote: assert property (@(posedge clk) disable iff (!arst_n)
		close_pend_q |-> in_arg_q && !in_quotes_q && run_q == '0)
		else $error("close quote pending in bad state");
`endif

endmodule

FILE: rtl/command_line_tokenizer.sv
// Top level of the command line tokenizer: front, queue and back joined.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, in_char               | in
//  output  | out_valid, out_ready, lead_backslashes,   | out
//          | char_valid, out_char, arg_start, arg_end, |
//          | line_done, arg_total, char_total          |
//
// One character per cycle sustained while the output does not stall; a result
// passes through a queue slot, then the result register.
// The back executes one queued character per cycle unless the output stalls, and writes the result register.
// Reset clears all argument state, both totals and the queue.
// Output stalls hold the result register; the two-entry queue then fills and
// in_ready drops.
module command_line_tokenizer import clt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CHAR_W-1:0]  in_char,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [RUN_W-1:0]   lead_backslashes,
	output logic               char_valid,
	output logic [CHAR_W-1:0]  out_char,
	output logic               arg_start,
	output logic               arg_end,
	output logic               line_done,
	output logic [TOTAL_W-1:0] arg_total,
	output logic [TOTAL_W-1:0] char_total
);

	logic        q_full, q_push, q_pop, q_not_empty;
	char_class_t q_wdata, q_rdata;

	clt_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_char  (in_char),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	clt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rdata     (q_rdata)
	);

	clt_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_not_empty      (q_not_empty),
		.q_rdata          (q_rdata),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.lead_backslashes (lead_backslashes),
		.char_valid       (char_valid),
		.out_char         (out_char),
		.arg_start        (arg_start),
		.arg_end          (arg_end),
		.line_done        (line_done),
		.arg_total        (arg_total),
		.char_total       (char_total)
	);

endmodule
